/* design/lphm_pkg.sv */
// Shared types and constants for the linear-probe hash map.
// No dependencies; imported by lphm_hash and linear_probe_hash_map_unit.
`timescale 1ns / 1ps
`default_nettype none

package lphm_pkg;

  // Field widths.
  localparam int KEY_W = 32;
  localparam int VAL_W = 16;
  localparam int OP_W  = 2;
  localparam int ST_W  = 3;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [ST_W-1:0] ST_UPDATED  = 3'd1;
  localparam logic [ST_W-1:0] ST_REMOVED  = 3'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd4;
  localparam logic [ST_W-1:0] ST_HIT      = 3'd5;

  // Reserved key codes and the multiplicative hash constant.
  localparam logic [KEY_W-1:0] KEY_EMPTY = 32'h0000_0000;
  localparam logic [KEY_W-1:0] KEY_TOMB  = 32'hFFFF_FFFF;
  localparam logic [KEY_W-1:0] HASH_MULT = 32'd2654435761;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE
  } state_t;

endpackage

`default_nettype wire

/* design/lphm_hash.sv */
// Start-slot hash: low slot-index bits of key times the hash constant, registered.
// Depends on lphm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lphm_hash #(
  parameter int IW = 10
) (
  input  logic                       clk,
  input  logic                       load,
  input  logic [lphm_pkg::KEY_W-1:0] key,
  output logic [IW-1:0]              slot
);
  import lphm_pkg::*;

  // Only the low IW bits of the product are kept, and they depend only on
  // the low IW bits of each operand.
  localparam logic [IW-1:0] MULT_LO = HASH_MULT[IW-1:0];

  logic [IW-1:0] prod;
  logic [IW-1:0] slot_r;

  assign prod = key[IW-1:0] * MULT_LO;

  // Register the product so the multiplier stands alone in its path.
  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= prod;
    end
  end

  assign slot = slot_r;

endmodule

`default_nettype wire

/* design/linear_probe_hash_map_unit.sv */
// Top level of the linear-probe hash map: sequencer, slot memory and live count.
// Depends on lphm_pkg and lphm_hash.
//
//   Channel  Ports                                   Handshake
//   input    in_opcode, in_item_key, in_item_value   transfer when start && !busy
//   result   out_status, out_found_value             one-cycle strobe out_valid
//
// After reset a clearing pass writes every slot empty, with busy high.
// An operation registers its key and start slot, reads the start slot in S_HASH and then
// probes in S_PROBE; the single read port of the slot memory gives one probe per cycle.
// A reserved key, an unused opcode or an insert into a half-full table answers in the
// cycle after the transfer. busy is low in the cycle the result is shown.
// The receiver cannot stall; each result is on the ports for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_hash_map_unit #(
  parameter int SLOTS = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [lphm_pkg::OP_W-1:0]  in_opcode,
  input  logic [lphm_pkg::KEY_W-1:0] in_item_key,
  input  logic [lphm_pkg::VAL_W-1:0] in_item_value,
  output logic                       out_valid,
  output logic [lphm_pkg::ST_W-1:0]  out_status,
  output logic [lphm_pkg::VAL_W-1:0] out_found_value
);
  import lphm_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int LW = IW + 1;
  localparam logic [IW-1:0] LAST_IDX  = IW'(SLOTS - 1);
  localparam logic [LW-1:0] LIVE_HALF = LW'(SLOTS / 2);

  state_t state_r, state_nxt;

  logic [IW-1:0]    clr_idx_r, clr_idx_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic [IW-1:0]    cnt_r, cnt_nxt;
  logic [LW-1:0]    live_r, live_nxt;
  logic [OP_W-1:0]  op_r, op_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]  out_status_r, out_status_nxt;
  logic [VAL_W-1:0] out_found_r, out_found_nxt;

  logic [IW-1:0]    hash_slot;
  logic             accept;
  logic             early_done;
  logic [ST_W-1:0]  early_status;

  // Slot memory and its port signals.
  logic [KEY_W-1:0] key_mem [SLOTS];
  logic [VAL_W-1:0] val_mem [SLOTS];
  logic [KEY_W-1:0] rd_key_r;
  logic [VAL_W-1:0] rd_val_r;
  logic [IW-1:0]    rd_addr;
  logic             mem_we;
  logic [IW-1:0]    wr_addr;
  logic [KEY_W-1:0] wr_key;
  logic [VAL_W-1:0] wr_val;

  // Probe decision for the slot that was just read.
  logic             probe_done;
  logic             probe_wr;
  logic [KEY_W-1:0] probe_wr_key;
  logic [VAL_W-1:0] probe_wr_val;
  logic [ST_W-1:0]  probe_status;
  logic [VAL_W-1:0] probe_found;
  logic             live_inc;
  logic             live_dec;

  assign accept = (state_r == S_IDLE) && start;

  lphm_hash #(
    .IW (IW)
  ) u_hash (
    .clk  (clk),
    .load (accept),
    .key  (in_item_key),
    .slot (hash_slot)
  );

  // Operations that finish without touching the table.
  always_comb begin
    early_done   = 1'b0;
    early_status = ST_NOTFOUND;
    if (in_item_key == KEY_EMPTY || in_item_key == KEY_TOMB) begin
      early_done = 1'b1;
    end else if (in_opcode == OP_INSERT) begin
      if (live_r >= LIVE_HALF) begin
        early_done   = 1'b1;
        early_status = ST_FULL;
      end
    end else if (in_opcode != OP_REMOVE && in_opcode != OP_LOOKUP) begin
      early_done = 1'b1;
    end
  end

  // Compare the read slot against the key and decide whether the probe ends.
  always_comb begin
    logic is_empty;
    logic is_tomb;
    logic is_key;
    logic is_last;
    is_empty     = (rd_key_r == KEY_EMPTY);
    is_tomb      = (rd_key_r == KEY_TOMB);
    is_key       = (rd_key_r == key_r);
    is_last      = (cnt_r == LAST_IDX);
    probe_done   = 1'b0;
    probe_wr     = 1'b0;
    probe_wr_key = key_r;
    probe_wr_val = val_r;
    probe_status = ST_NOTFOUND;
    probe_found  = '0;
    live_inc     = 1'b0;
    live_dec     = 1'b0;
    case (op_r)
      OP_INSERT: begin
        if (is_empty || is_tomb) begin
          probe_done   = 1'b1;
          probe_wr     = 1'b1;
          probe_status = ST_INSERTED;
          live_inc     = 1'b1;
        end else if (is_key) begin
          probe_done   = 1'b1;
          probe_wr     = 1'b1;
          probe_status = ST_UPDATED;
        end else if (is_last) begin
          probe_done   = 1'b1;
          probe_status = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (is_empty) begin
          probe_done = 1'b1;
        end else if (is_key) begin
          probe_done   = 1'b1;
          probe_wr     = 1'b1;
          probe_wr_key = KEY_TOMB;
          probe_wr_val = '0;
          probe_status = ST_REMOVED;
          live_dec     = (live_r != '0);
        end else if (is_last) begin
          probe_done = 1'b1;
        end
      end
      default: begin
        if (is_empty) begin
          probe_done = 1'b1;
        end else if (is_key && rd_val_r != '0) begin
          probe_done   = 1'b1;
          probe_status = ST_HIT;
          probe_found  = rd_val_r;
        end else if (is_last) begin
          probe_done = 1'b1;
        end
      end
    endcase
  end

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start && !early_done) begin
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        state_nxt = S_PROBE;
      end
      S_PROBE: begin
        if (probe_done) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  // Datapath, memory port and result outputs of the sequencer.
  always_comb begin
    clr_idx_nxt    = clr_idx_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    live_nxt       = live_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    rd_addr        = idx_r;
    mem_we         = 1'b0;
    wr_addr        = idx_r;
    wr_key         = probe_wr_key;
    wr_val         = probe_wr_val;
    unique case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        wr_addr     = clr_idx_r;
        wr_key      = KEY_EMPTY;
        wr_val      = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
      end
      S_IDLE: begin
        if (start) begin
          op_nxt  = in_opcode;
          key_nxt = in_item_key;
          val_nxt = in_item_value;
          if (early_done) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = early_status;
            out_found_nxt  = '0;
          end
        end
      end
      S_HASH: begin
        rd_addr = hash_slot;
        idx_nxt = hash_slot;
        cnt_nxt = '0;
      end
      S_PROBE: begin
        if (probe_done) begin
          mem_we         = probe_wr;
          out_valid_nxt  = 1'b1;
          out_status_nxt = probe_status;
          out_found_nxt  = probe_found;
          if (live_inc) begin
            live_nxt = live_r + 1'b1;
          end else if (live_dec) begin
            live_nxt = live_r - 1'b1;
          end
        end else begin
          // Read the next slot, wrapping at the end of the table.
          rd_addr = idx_r + 1'b1;
          idx_nxt = idx_r + 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
    endcase
  end

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
    rd_key_r <= key_mem[rd_addr];
    rd_val_r <= val_mem[rd_addr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    cnt_r        <= cnt_nxt;
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_found_r;

`ifndef NO_ASSERTIONS
  // The live count never passes half the table.
  a_live_bound : assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= LIVE_HALF)
    else $error("live count exceeds half the slots");

  // The memory is written only by the clearing pass or at the end of a probe.
  a_write_state : assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR || (state_r == S_PROBE && probe_done)))
    else $error("slot memory written outside a clear or probe end");

  // A change of the live count comes with a result strobe.
  a_live_result : assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && live_r != $past(live_r)) |-> out_valid)
    else $error("live count changed without a result");

  // A lookup hit always carries a non-zero handle.
  a_hit_value : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_HIT) |-> (out_found_value != '0))
    else $error("lookup hit with a zero handle");

  // No result appears while the table is still being cleared.
  a_no_result_clear : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |=> !out_valid)
    else $error("result during the clearing pass");
`endif

endmodule

`default_nettype wire

/* bench/tb.sv */
// Self-checking bench for linear_probe_hash_map_unit: directed and random map operations,
// each result checked against an in-bench model of the open-addressed table.
// Depends on lphm_pkg and the RTL of linear_probe_hash_map_unit.
`timescale 1ns / 1ps

module tb;
  import lphm_pkg::*;

  localparam int SLOTS         = 1024;
  localparam int CYCLE_LIMIT   = 8_000_000;
  localparam int SETTLE_CYCLES = 64;

  // Opcode 3 has no meaning to the block; it must answer not found.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } map_op_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [VAL_W-1:0] found;
  } outcome_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [OP_W-1:0]  in_opcode = '0;
  logic [KEY_W-1:0] in_item_key = '0;
  logic [VAL_W-1:0] in_item_value = '0;
  logic             out_valid;
  logic [ST_W-1:0]  out_status;
  logic [VAL_W-1:0] out_found_value;

  // Shadow copy of the table, updated as each operation is accepted.
  logic [KEY_W-1:0] map_keys [SLOTS];
  logic [VAL_W-1:0] map_vals [SLOTS];
  int               map_live = 0;

  map_op_t          op_q[$];
  outcome_t         outcome_q[$];
  logic [KEY_W-1:0] key_pool[$];

  int sent_total = 0;
  int xfer_total = 0;
  int idle_pct = 0;
  int fail_count = 0;
  int status_tally [6];
  int cycle_count = 0;

  linear_probe_hash_map_unit #(.SLOTS(SLOTS)) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_item_key     (in_item_key),
    .in_item_value   (in_item_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_found_value (out_found_value)
  );

  always #10 clk = ~clk;

  // Start slot: low bits of the 32-bit product of the key and the hash constant.
  function automatic int unsigned home_slot(logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] prod;
    prod = key * HASH_MULT;
    return prod & (SLOTS - 1);
  endfunction

  // Applies one operation to the shadow table and returns the result it must give.
  function automatic outcome_t map_apply(map_op_t op);
    outcome_t         res;
    int unsigned      idx;
    logic [KEY_W-1:0] k;
    bit               done;
    int               i;
    res.status = ST_NOTFOUND;
    res.found  = '0;
    done       = 1'b0;
    if (op.key == KEY_EMPTY || op.key == KEY_TOMB) return res;
    idx = home_slot(op.key);
    case (op.opcode)
      OP_INSERT: begin
        res.status = ST_FULL;
        // A half-full table refuses every insert, even an update.
        if (map_live * 2 >= SLOTS) return res;
        for (i = 0; i < SLOTS && !done; i++) begin
          k = map_keys[idx];
          if (k == KEY_EMPTY || k == KEY_TOMB) begin
            map_keys[idx] = op.key;
            map_vals[idx] = op.value;
            map_live++;
            res.status = ST_INSERTED;
            done = 1'b1;
          end else if (k == op.key) begin
            map_vals[idx] = op.value;
            res.status = ST_UPDATED;
            done = 1'b1;
          end
          idx = (idx + 1) % SLOTS;
        end
      end
      OP_REMOVE: begin
        for (i = 0; i < SLOTS && !done; i++) begin
          k = map_keys[idx];
          if (k == KEY_EMPTY) begin
            done = 1'b1;
          end else if (k == op.key) begin
            map_keys[idx] = KEY_TOMB;
            map_vals[idx] = '0;
            if (map_live > 0) map_live--;
            res.status = ST_REMOVED;
            done = 1'b1;
          end
          idx = (idx + 1) % SLOTS;
        end
      end
      OP_LOOKUP: begin
        // A matching key with a zero value does not end the probe.
        for (i = 0; i < SLOTS && !done; i++) begin
          k = map_keys[idx];
          if (k == KEY_EMPTY) begin
            done = 1'b1;
          end else if (k == op.key && map_vals[idx] != '0) begin
            res.status = ST_HIT;
            res.found  = map_vals[idx];
            done = 1'b1;
          end
          idx = (idx + 1) % SLOTS;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void queue_op(logic [OP_W-1:0] opcode, logic [KEY_W-1:0] key,
                                   logic [VAL_W-1:0] value);
    map_op_t op;
    op.opcode = opcode;
    op.key    = key;
    op.value  = value;
    op_q.push_back(op);
  endfunction

  // Picks a seen key pool_pct percent of the time, for updates, removes and hits.
  function automatic logic [KEY_W-1:0] pick_key(int pool_pct);
    logic [KEY_W-1:0] k;
    if (key_pool.size() > 0 && $urandom_range(99) < pool_pct)
      return key_pool[$urandom_range(key_pool.size() - 1)];
    k = $urandom;
    while (k == KEY_EMPTY || k == KEY_TOMB) k = $urandom;
    key_pool.push_back(k);
    return k;
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    int r;
    r = $urandom_range(99);
    if (r < 6) return '0;
    if (r < 9) return '1;
    return VAL_W'($urandom_range(16'hFFFF));
  endfunction

  function automatic logic [OP_W-1:0] pick_op(int ins_pct, int rem_pct);
    int r;
    r = $urandom_range(99);
    if (r < ins_pct) return OP_INSERT;
    if (r < ins_pct + rem_pct) return OP_REMOVE;
    return OP_LOOKUP;
  endfunction

  // Random operations with a little noise: unused opcode and reserved keys.
  function automatic void push_mixed(int n, int ins_pct, int rem_pct);
    int i;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(99) < 4) begin
        if ($urandom_range(1) == 0)
          queue_op(OP_UNUSED, pick_key(80), rand_value());
        else
          queue_op(pick_op(34, 33), ($urandom_range(1) == 0) ? KEY_EMPTY : KEY_TOMB,
                   rand_value());
      end else begin
        queue_op(pick_op(ins_pct, rem_pct), pick_key(85), rand_value());
      end
    end
  endfunction

  // Holds the stimulus back until every queued operation has returned its result.
  task automatic wait_drained();
    @(negedge clk);
    while (!(op_q.size() == 0 && sent_total == xfer_total && outcome_q.size() == 0))
      @(negedge clk);
  endtask

  // Driver: offers the next operation at the falling edge once the previous transfer is done.
  always @(negedge clk) begin : driver
    map_op_t nxt;
    if (sent_total == xfer_total) begin
      if (rst_n && op_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        nxt = op_q.pop_front();
        in_opcode     <= nxt.opcode;
        in_item_key   <= nxt.key;
        in_item_value <= nxt.value;
        start         <= 1'b1;
        sent_total++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks each result strobe, then records any transfer at this edge.
  always @(posedge clk) begin : monitor
    outcome_t want;
    map_op_t  taken;
    if (rst_n) begin
      if (out_valid) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result status=%0d found=%h", $time, out_status,
                   out_found_value);
          fail_count++;
        end else begin
          want = outcome_q.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d", $time, want.status,
                     out_status);
            fail_count++;
          end
          if (out_found_value !== want.found) begin
            $display("%0t: found_value mismatch, expected %h, actual %h", $time, want.found,
                     out_found_value);
            fail_count++;
          end
          if (out_status < 6) status_tally[out_status]++;
        end
      end
      if (start && !busy) begin
        taken.opcode = in_opcode;
        taken.key    = in_item_key;
        taken.value  = in_item_value;
        outcome_q.push_back(map_apply(taken));
        xfer_total++;
      end
    end
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run stopped after %0d cycles", $time, cycle_count);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    logic [KEY_W-1:0] base;
    int               b;
    int               n;
    int               rounds;
    for (b = 0; b < SLOTS; b++) begin
      map_keys[b] = KEY_EMPTY;
      map_vals[b] = '0;
    end
    for (b = 0; b < 6; b++) status_tally[b] = 0;

    // Seed the key pool with clusters that share a start slot (keys 1024 apart).
    for (b = 0; b < 6; b++) begin
      base = $urandom_range(32'h0FFF_FFFF, 1);
      for (n = 0; n < 8; n++) key_pool.push_back(base + n * SLOTS);
    end

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, zero values, key extremes, reserved keys, unused opcode,
    // probing past a tombstone and a duplicate key left by reuse of a tombstone.
    queue_op(OP_LOOKUP, 32'd1, 16'h0000);
    queue_op(OP_REMOVE, 32'd1, 16'h0000);
    queue_op(OP_INSERT, 32'd1, 16'hFFFF);
    queue_op(OP_INSERT, 32'd1, 16'h0000);
    queue_op(OP_LOOKUP, 32'd1, 16'h0000);
    queue_op(OP_INSERT, 32'd1, 16'h1234);
    queue_op(OP_LOOKUP, 32'd1, 16'h0000);
    queue_op(OP_INSERT, 32'hFFFF_FFFE, 16'h0001);
    queue_op(OP_LOOKUP, 32'hFFFF_FFFE, 16'h0000);
    queue_op(OP_INSERT, KEY_EMPTY, 16'hABCD);
    queue_op(OP_LOOKUP, KEY_EMPTY, 16'h0000);
    queue_op(OP_REMOVE, KEY_TOMB, 16'h0000);
    queue_op(OP_INSERT, KEY_TOMB, 16'h0001);
    queue_op(OP_UNUSED, 32'd1, 16'h5555);
    queue_op(OP_INSERT, 32'd5, 16'h0005);
    queue_op(OP_INSERT, 32'd5 + SLOTS, 16'h0405);
    queue_op(OP_INSERT, 32'd5 + 2 * SLOTS, 16'h0805);
    queue_op(OP_REMOVE, 32'd5 + SLOTS, 16'h0000);
    queue_op(OP_LOOKUP, 32'd5 + 2 * SLOTS, 16'h0000);
    queue_op(OP_INSERT, 32'd5 + 2 * SLOTS, 16'h7777);
    queue_op(OP_LOOKUP, 32'd5 + 2 * SLOTS, 16'h0000);
    queue_op(OP_REMOVE, 32'd5 + 2 * SLOTS, 16'h0000);
    queue_op(OP_LOOKUP, 32'd5 + 2 * SLOTS, 16'h0000);
    queue_op(OP_REMOVE, 32'd1, 16'h0000);
    queue_op(OP_REMOVE, 32'd1, 16'h0000);
    wait_drained();

    // Fill the table to half its slots so that inserts start to report full.
    idle_pct = 24;
    rounds = 0;
    while (map_live * 2 < SLOTS && rounds < 40) begin
      for (n = 0; n < 32; n++) queue_op(OP_INSERT, pick_key(10), rand_value());
      wait_drained();
      rounds++;
    end
    push_mixed(100, 45, 20);
    wait_drained();

    // Remove-heavy traffic shrinks the live count and leaves many tombstones.
    idle_pct = 55;
    push_mixed(300, 15, 50);
    wait_drained();

    // Back-to-back balanced traffic.
    idle_pct = 0;
    push_mixed(320, 35, 25);
    wait_drained();

    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Checked %0d operations: %0d inserted, %0d updated, %0d removed,", xfer_total,
             status_tally[ST_INSERTED], status_tally[ST_UPDATED], status_tally[ST_REMOVED]);
    $display("%0d not found, %0d full, %0d lookup hits; %0d mismatches.",
             status_tally[ST_NOTFOUND], status_tally[ST_FULL], status_tally[ST_HIT],
             fail_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
